// ===== rtl/join_conflict_tes_calculator_top_defines.svh =====
// Assertion macros for the checker file.
// No dependencies; included by the checker.
`ifndef JOIN_CONFLICT_TES_CALCULATOR_TOP_DEFINES_SVH
`define JOIN_CONFLICT_TES_CALCULATOR_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define JCTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk_a) disable iff (!rst_na) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define JCTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk_a) disable iff (!rst_na) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/jctc_pkg.sv =====
// Shared types, constants and the operator classifier.
// No dependencies.
package jctc_pkg;

    localparam int P_MAX_RELATIONS = 32;
    localparam int P_MAX_OPERATORS = 32;
    localparam int MASK_W          = 32;
    localparam int CODE_W          = 3;
    localparam int S_TDATA_W       = 96;
    localparam int S_TUSER_W       = 7;
    localparam int M_TDATA_W       = 128;
    localparam int M_TUSER_W       = 8;

    localparam logic [CODE_W-1:0] KIND_LEFT   = 3'd1;
    localparam logic [CODE_W-1:0] KIND_RIGHT  = 3'd2;
    localparam logic [CODE_W-1:0] KIND_FULL   = 3'd3;
    localparam logic [CODE_W-1:0] STRICT_SEMI = 3'd0;
    localparam logic [CODE_W-1:0] STRICT_ANTI = 3'd1;

    typedef enum logic [2:0] {
        CAT_JOIN, CAT_LOUTER, CAT_ROUTER, CAT_FULL,
        CAT_LSEMI, CAT_RSEMI, CAT_LANTI, CAT_RANTI
    } t_cat;

    typedef enum logic [1:0] {PH_NONE, PH_UNION, PH_UPDATE, PH_SCAN} t_phase;

    typedef struct packed {
        logic   ld;        // capture input beat
        logic   cnt_clr;
        logic   cnt_inc;
        t_phase phase;
        logic   commit;    // store blocker if not reorderable and room left, load output register
    } t_cmd;

    typedef struct packed {
        logic rel_end;
        logic scan_end;
        logic is_sa;
        logic out_free;
    } t_status;

    function automatic t_cat cat_of(input logic [CODE_W-1:0] kind,
                                    input logic [CODE_W-1:0] strict);
        t_cat c;
        if (strict == STRICT_SEMI)      c = (kind == KIND_RIGHT) ? CAT_RSEMI : CAT_LSEMI;
        else if (strict == STRICT_ANTI) c = (kind == KIND_RIGHT) ? CAT_RANTI : CAT_LANTI;
        else if (kind == KIND_LEFT)     c = CAT_LOUTER;
        else if (kind == KIND_RIGHT)    c = CAT_ROUTER;
        else if (kind == KIND_FULL)     c = CAT_FULL;
        else                            c = CAT_JOIN;
        return c;
    endfunction

endpackage

// ===== rtl/jctc_ctrl.sv =====
// Sequencer: union pass, update pass, blocker scan (semi/anti only), commit.
// Depends on jctc_pkg.
module jctc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  jctc_pkg::t_status i_st,
    output jctc_pkg::t_cmd  o_cmd
);
    import jctc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_UNION, S_UPDATE, S_SCAN, S_COMMIT} t_state;
    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '{ld: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, phase: PH_NONE, commit: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld      = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_UNION;
                end
            end
            S_UNION: begin
                o_cmd.phase   = PH_UNION;
                o_cmd.cnt_inc = 1'b1;
                if (i_st.rel_end) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.phase   = PH_UPDATE;
                o_cmd.cnt_inc = 1'b1;
                if (i_st.rel_end) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = i_st.is_sa ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                o_cmd.phase   = PH_SCAN;
                o_cmd.cnt_inc = 1'b1;
                if (i_st.scan_end) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_st.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== rtl/jctc_dp.sv =====
// Datapath: relation set memories, blocker store, accumulators, output register.
// Depends on jctc_pkg.
module jctc_dp #(
    parameter int MAX_RELATIONS = jctc_pkg::P_MAX_RELATIONS,
    parameter int MAX_OPERATORS = jctc_pkg::P_MAX_OPERATORS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  jctc_pkg::t_cmd                 i_cmd,
    output jctc_pkg::t_status              o_st,
    input  logic [jctc_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [jctc_pkg::S_TUSER_W-1:0] i_tuser,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [jctc_pkg::M_TDATA_W-1:0] o_tdata,
    output logic [jctc_pkg::M_TUSER_W-1:0] o_tuser
);
    import jctc_pkg::*;

    localparam int RW   = $clog2(MAX_RELATIONS);
    localparam int OW   = (MAX_OPERATORS > 1) ? $clog2(MAX_OPERATORS) : 1;
    localparam int CNTW = $clog2(MAX_OPERATORS + 1);
    localparam int IW   = ((RW + 1) > CNTW) ? (RW + 1) : CNTW;

    // captured operator
    logic [MASK_W-1:0] r_left, r_right, r_pred;
    logic [CODE_W-1:0] r_kind, r_strict;

    logic [MASK_W-1:0] r_outer_mem [MAX_RELATIONS];
    logic [MASK_W-1:0] r_anti_mem  [MAX_RELATIONS];
    logic [MASK_W-1:0] r_store_mem [MAX_OPERATORS];
    logic [MAX_RELATIONS-1:0] r_outer_vld, r_anti_vld;

    logic [IW-1:0]     r_idx;
    logic [CNTW-1:0]   r_count;
    logic              r_pend, r_spend;
    logic [RW-1:0]     r_pidx;
    logic [MASK_W-1:0] r_outer_q, r_anti_q, r_store_q;
    logic              r_outer_vq, r_anti_vq;
    logic [MASK_W-1:0] r_u_outer_bad, r_u_anti_good, r_w;
    logic              r_push;
    logic              r_ovalid;
    logic [M_TDATA_W-1:0] r_odata;
    logic [M_TUSER_W-1:0] r_ouser;

    t_cat              cat;
    logic [MASK_W-1:0] both, good, bad, eel, onehot, outer_val, anti_val;
    logic              is_sa, free_op, issue_rel, issue_scan, outer_we, anti_we, hit;
    logic              store_we;
    logic              union_ph, update_ph, scan_ph;

    assign cat     = cat_of(r_kind, r_strict);
    assign both    = r_left | r_right;
    assign is_sa   = (r_strict == STRICT_SEMI) || (r_strict == STRICT_ANTI);
    assign free_op = (cat == CAT_JOIN);

    always_comb begin
        case (cat)
            CAT_LOUTER, CAT_LANTI: begin good = r_left;  bad = r_right; end
            CAT_ROUTER, CAT_RANTI: begin good = r_right; bad = r_left;  end
            CAT_FULL:              begin good = '0;      bad = both;    end
            default:               begin good = both;    bad = '0;      end
        endcase
        case (cat)
            CAT_LOUTER, CAT_ROUTER: eel = r_pred | r_u_outer_bad;
            CAT_LANTI, CAT_RANTI:   eel = r_pred | r_u_anti_good | bad;
            default:                eel = r_pred;
        endcase
    end

    assign union_ph   = (i_cmd.phase == PH_UNION);
    assign update_ph  = (i_cmd.phase == PH_UPDATE);
    assign scan_ph    = (i_cmd.phase == PH_SCAN);
    assign o_st.rel_end  = (r_idx == IW'(MAX_RELATIONS));
    assign o_st.scan_end = (r_idx >= IW'(r_count));
    assign o_st.is_sa    = is_sa;
    assign o_st.out_free = !r_ovalid || i_tready;
    assign issue_rel  = (union_ph || update_ph) && (r_idx < IW'(MAX_RELATIONS));
    assign issue_scan = scan_ph && !o_st.scan_end;

    // unwritten entries read as their singleton
    assign onehot    = MASK_W'(1) << r_pidx;
    assign outer_val = r_outer_vq ? r_outer_q : onehot;
    assign anti_val  = r_anti_vq  ? r_anti_q  : onehot;

    assign outer_we = r_pend && update_ph && r_w[r_pidx] &&
                      ((cat == CAT_JOIN) || (cat == CAT_LANTI) || (cat == CAT_RANTI));
    assign anti_we  = r_pend && update_ph && bad[r_pidx] &&
                      ((cat == CAT_LOUTER) || (cat == CAT_ROUTER));
    assign hit      = r_spend && scan_ph && ((r_store_q & ~both) == '0) && (r_store_q != both);
    assign store_we = i_cmd.commit && !free_op && (r_count < CNTW'(MAX_OPERATORS));

    // relation set memories
    always_ff @(posedge i_clk) begin
        if (issue_rel) begin
            r_outer_q  <= r_outer_mem[r_idx[RW-1:0]];
            r_anti_q   <= r_anti_mem[r_idx[RW-1:0]];
            r_outer_vq <= r_outer_vld[r_idx[RW-1:0]];
            r_anti_vq  <= r_anti_vld[r_idx[RW-1:0]];
            r_pidx     <= r_idx[RW-1:0];
        end
        if (outer_we) r_outer_mem[r_pidx] <= r_w;
        if (anti_we)  r_anti_mem[r_pidx]  <= anti_val | r_u_anti_good;
    end

    // blocker store
    always_ff @(posedge i_clk) begin
        if (issue_scan) r_store_q <= r_store_mem[r_idx[OW-1:0]];
        if (store_we)   r_store_mem[r_count[OW-1:0]] <= both;
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_left        <= i_tdata[31:0];
            r_right       <= i_tdata[63:32];
            r_pred        <= i_tdata[95:64];
            r_kind        <= i_tuser[3:1];
            r_strict      <= i_tuser[6:4];
            r_u_outer_bad <= '0;
            r_u_anti_good <= '0;
            r_w           <= '0;
            r_push        <= 1'b1;
        end else begin
            if (r_pend && union_ph) begin
                if (r_pred[r_pidx] && bad[r_pidx])  r_u_outer_bad <= r_u_outer_bad | outer_val;
                if (r_pred[r_pidx] && good[r_pidx]) r_u_anti_good <= r_u_anti_good | anti_val;
                if (r_pred[r_pidx])                 r_w           <= r_w | outer_val;
            end
            if (hit) r_push <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_odata <= {r_pred, eel & r_right, eel & r_left, both};
            r_ouser <= {is_sa & r_push, free_op, r_strict, r_kind};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_spend     <= 1'b0;
            r_outer_vld <= '0;
            r_anti_vld  <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_pend  <= issue_rel;
            r_spend <= issue_scan;
            if (i_cmd.cnt_clr)      r_idx <= '0;
            else if (i_cmd.cnt_inc) r_idx <= r_idx + IW'(1);
            if (i_cmd.ld && i_tuser[0]) begin
                r_outer_vld <= '0;
                r_anti_vld  <= '0;
                r_count     <= '0;
            end else begin
                if (outer_we) r_outer_vld[r_pidx] <= 1'b1;
                if (anti_we)  r_anti_vld[r_pidx]  <= 1'b1;
                if (store_we) r_count <= r_count + CNTW'(1);
            end
            if (i_cmd.commit)              r_ovalid <= 1'b1;
            else if (r_ovalid && i_tready) r_ovalid <= 1'b0;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_ouser;

endmodule

// ===== rtl/join_conflict_tes_calculator_top.sv =====
// Join conflict eligibility (TES) calculator, top level.
// Input beat: one join operator of a query, bottom-up order; s_tuser[0]
//   marks the first operator of a new query, which resets the per-relation
//   outer and anti sets and empties the blocker store before it is handled.
// Output beat: one result per operator, in order.
// Per operator the sequencer runs a union pass over the relation set
//   memories (one relation a cycle), an update pass (one relation a cycle,
//   read-modify-write), and for semi/anti operators a scan of the stored
//   non-reorderable operators (one a cycle), then commits.
// s_tready is high only when idle.
// The result sits in an output register: the next operator is taken while
//   it waits; a stall on m_tready only holds the commit of the one after.
// Reset (synchronous, active low) empties the sets and store and drops
//   m_tvalid; no clearing pass is needed.
// Depends on jctc_pkg, jctc_ctrl, jctc_dp.
module join_conflict_tes_calculator_top #(
    parameter int MAX_RELATIONS = jctc_pkg::P_MAX_RELATIONS,
    parameter int MAX_OPERATORS = jctc_pkg::P_MAX_OPERATORS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // left_mask[31:0], right_mask[63:32], pred_mask[95:64]
    input  logic [jctc_pkg::S_TDATA_W-1:0] s_tdata,
    // new_query[0], join_kind[3:1], strictness[6:4]
    input  logic [jctc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // relations[31:0], left_tes[63:32], right_tes[95:64], pred_out[127:96]
    output logic [jctc_pkg::M_TDATA_W-1:0] m_tdata,
    // kind_out[2:0], strictness_out[5:3], reorder_ok[6], push_ok[7]
    output logic [jctc_pkg::M_TUSER_W-1:0] m_tuser
);
    import jctc_pkg::*;

    t_cmd    cmd;
    t_status st;

    jctc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    jctc_dp #(
        .MAX_RELATIONS (MAX_RELATIONS),
        .MAX_OPERATORS (MAX_OPERATORS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_st     (st),
        .i_tdata  (s_tdata),
        .i_tuser  (s_tuser),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_tdata  (m_tdata),
        .o_tuser  (m_tuser)
    );

endmodule

// ===== rtl/jctc_checker.sv =====
// Port-level checker for the TES calculator, bound to the top level.
// Depends on jctc_pkg and join_conflict_tes_calculator_top_defines.svh.
`include "join_conflict_tes_calculator_top_defines.svh"
module jctc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [jctc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [jctc_pkg::M_TUSER_W-1:0] m_tuser
);
    logic clk_a, rst_na;
    logic [31:0] tes_any;
    assign clk_a   = i_clk;
    assign rst_na  = i_rst_n;
    assign tes_any = m_tdata[63:32] | m_tdata[95:64];

    // a result beat held until taken
    `JCTC_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    // one operator in flight: ready drops after every accepted beat
    `JCTC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "beat accepted back to back")
    // reorderable operators are never semi/anti, so never pushdown
    `JCTC_ASSERT_NOW(a_free_no_push, m_tvalid && m_tuser[6], !m_tuser[7], "free op flagged pushdown")
    // eligibility parts stay inside the operator's relations
    `JCTC_ASSERT_NOW(a_tes_subset, m_tvalid, (tes_any & ~m_tdata[31:0]) == '0, "TES outside relations")

endmodule

bind join_conflict_tes_calculator_top jctc_checker u_jctc_checker (.*);

// ===== dv/tb_join_conflict_tes_calculator_top.sv =====
// Testbench for the join conflict eligibility (TES) calculator.
// Drives operator beats from a queue, predicts each result with a local
//   model of the relation sets and blocker store; depends on jctc_pkg and the top.
`timescale 1ns / 100ps

module tb_join_conflict_tes_calculator_top;
    import jctc_pkg::*;

    localparam int NREL = P_MAX_RELATIONS;
    localparam int NOPS = P_MAX_OPERATORS;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [6:0]  user;
        logic [95:0] data;
    } t_op_beat;

    typedef struct packed {
        logic [7:0]   user;
        logic [127:0] data;
    } t_tes_result;

    logic i_clk, i_rst_n;
    logic s_tvalid, s_tready, m_tvalid, m_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    join_conflict_tes_calculator_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // predictor state
    logic [31:0] mdl_outer [NREL];
    logic [31:0] mdl_anti  [NREL];
    logic [31:0] blocker_mask [NOPS];
    int          blocker_cnt;

    t_op_beat    op_queue[$];
    t_tes_result tes_expected[$];
    int          n_errors = 0;
    int          src_idle_pct = 0, snk_idle_pct = 0;
    int          n_sent = 0;
    bit          snk_hold = 1'b0;
    longint      cycle_cnt = 0;

    function automatic logic [31:0] union_of(input logic [31:0] sets [NREL],
                                             input logic [31:0] m);
        logic [31:0] acc;
        acc = '0;
        for (int i = 0; i < NREL; i++)
            if (m[i]) acc |= sets[i];
        return acc;
    endfunction

    // Predict the result of one operator and update the query state.
    function automatic t_tes_result predict_tes(input t_op_beat b);
        logic [31:0] lm, rm, pm, both, good, bad, eel, w, o;
        logic [2:0]  kind, strict;
        t_cat        cat;
        logic        free_op, push;
        t_tes_result r;
        lm = b.data[31:0]; rm = b.data[63:32]; pm = b.data[95:64];
        kind = b.user[3:1]; strict = b.user[6:4];
        both = lm | rm;
        if (b.user[0]) begin
            for (int i = 0; i < NREL; i++) begin
                mdl_outer[i] = 32'd1 << i;
                mdl_anti[i]  = 32'd1 << i;
            end
            blocker_cnt = 0;
        end
        if (strict == STRICT_SEMI)      cat = (kind == KIND_RIGHT) ? CAT_RSEMI : CAT_LSEMI;
        else if (strict == STRICT_ANTI) cat = (kind == KIND_RIGHT) ? CAT_RANTI : CAT_LANTI;
        else if (kind == KIND_LEFT)     cat = CAT_LOUTER;
        else if (kind == KIND_RIGHT)    cat = CAT_ROUTER;
        else if (kind == KIND_FULL)     cat = CAT_FULL;
        else                            cat = CAT_JOIN;
        case (cat)
            CAT_LOUTER, CAT_LANTI: begin good = lm; bad = rm; end
            CAT_ROUTER, CAT_RANTI: begin good = rm; bad = lm; end
            CAT_FULL: begin good = '0; bad = both; end
            default: begin good = both; bad = '0; end
        endcase
        eel = pm;
        if (cat == CAT_LOUTER || cat == CAT_ROUTER)
            eel |= union_of(mdl_outer, pm & bad);
        else if (cat == CAT_LANTI || cat == CAT_RANTI)
            eel |= union_of(mdl_anti, pm & good) | bad;
        if (cat == CAT_JOIN || cat == CAT_LANTI || cat == CAT_RANTI) begin
            w = union_of(mdl_outer, pm);
            for (int i = 0; i < NREL; i++)
                if (w[i]) mdl_outer[i] = w;
        end else if (cat == CAT_LOUTER || cat == CAT_ROUTER) begin
            w = union_of(mdl_anti, pm & good);
            for (int i = 0; i < NREL; i++)
                if (bad[i]) mdl_anti[i] |= w;
        end
        free_op = (cat == CAT_JOIN);
        push = 1'b0;
        if (strict == STRICT_SEMI || strict == STRICT_ANTI) begin
            push = 1'b1;
            for (int i = 0; i < blocker_cnt; i++) begin
                o = blocker_mask[i];
                if ((o & ~both) == '0 && o != both) push = 1'b0;
            end
        end
        if (!free_op && blocker_cnt < NOPS) begin
            blocker_mask[blocker_cnt] = both;
            blocker_cnt++;
        end
        r.data = {pm, eel & rm, eel & lm, both};
        r.user = {push, free_op, strict, kind};
        return r;
    endfunction

    function automatic t_op_beat make_op(input bit nq, input logic [31:0] lm,
                                         input logic [31:0] rm, input logic [31:0] pm,
                                         input logic [2:0] kind, input logic [2:0] strict);
        t_op_beat b;
        b.data = {pm, rm, lm};
        b.user = {strict, kind, nq};
        return b;
    endfunction

    function automatic void enqueue_op(input t_op_beat b);
        op_queue.insert(op_queue.size(), b);
    endfunction

    // Random mask biased toward a few relations so sets interact.
    function automatic logic [31:0] rand_mask(input int span);
        logic [31:0] m;
        m = '0;
        case ($urandom_range(0, 9))
            0: m = $urandom();
            1: m = '1;
            default: for (int k = 0; k < $urandom_range(1, 3); k++)
                m[$urandom_range(0, span - 1)] = 1'b1;
        endcase
        return m;
    endfunction

    // Driver: one beat in flight, valid held until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                tes_expected.insert(tes_expected.size(), predict_tes({s_tuser, s_tdata}));
                n_sent <= n_sent + 1;
            end
            if (op_queue.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                {s_tuser, s_tdata} <= op_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, or held low through a long hold.
    always @(posedge i_clk) begin
        if (snk_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Long receiver hold early on so the block backs up.
    initial begin
        wait (n_sent >= 40);
        @(posedge i_clk);
        snk_hold <= 1'b1;
        repeat (2000) @(posedge i_clk);
        snk_hold <= 1'b0;
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_tes_result exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (tes_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat %h", {m_tuser, m_tdata});
            end else begin
                exp_r = tes_expected.pop_front();
                if (exp_r !== {m_tuser, m_tdata}) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: rel %h/%h tesL %h/%h tesR %h/%h pred %h/%h user %h/%h",
                                 exp_r.data[31:0], m_tdata[31:0], exp_r.data[63:32],
                                 m_tdata[63:32], exp_r.data[95:64], m_tdata[95:64],
                                 exp_r.data[127:96], m_tdata[127:96], exp_r.user, m_tuser);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int span;
        bit nq;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every kind, semi/anti both sides, extreme masks
        enqueue_op(make_op(1, '0, '0, '0, 3'd0, 3'd7));
        enqueue_op(make_op(0, '1, '1, '1, 3'd7, 3'd7));
        for (int k = 0; k < 8; k++)
            enqueue_op(make_op(k == 0, 32'h1 << k, 32'h2 << k, 32'h3 << k,
                               k[2:0], 3'd2));
        enqueue_op(make_op(0, 32'h3, 32'h4, 32'h7, KIND_RIGHT, STRICT_SEMI));
        enqueue_op(make_op(0, 32'h7, 32'h8, 32'hF, KIND_RIGHT, STRICT_ANTI));
        enqueue_op(make_op(0, 32'h1, 32'h80000000, 32'h80000001, KIND_LEFT, STRICT_ANTI));
        enqueue_op(make_op(0, 32'hF, 32'h10, 32'h18, KIND_LEFT, STRICT_SEMI));
        enqueue_op(make_op(0, 32'hFFFF, 32'hFFFF0000, 32'h00018000, KIND_FULL, 3'd5));
        // add to the blocker store with outer joins, then a semi probe
        for (int k = 0; k < 8; k++)
            enqueue_op(make_op(0, 32'h1 << k, 32'h1 << (k + 1), 32'h3 << k,
                               KIND_LEFT, 3'd3));
        enqueue_op(make_op(0, '1, '1, 32'h5, 3'd0, STRICT_SEMI));

        // random: queries of 1..40 operators with growing relation sets
        for (int n = 0; n < 1600; n++) begin
            if (n % 40 == 0 || $urandom_range(0, 30) == 0) span = $urandom_range(2, 32);
            nq = (n % 40 == 0) || ($urandom_range(0, 25) == 0);
            enqueue_op(make_op(nq, rand_mask(span), rand_mask(span), rand_mask(span),
                               3'($urandom_range(0, 7)),
                               3'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1)
                                                              : $urandom_range(0, 7))));
        end

        // idle phases: sender 34 / receiver 57, then swapped, then none
        src_idle_pct = 34; snk_idle_pct = 57;
        wait (n_sent >= 540);
        src_idle_pct = 57; snk_idle_pct = 34;
        wait (n_sent >= 1080);
        src_idle_pct = 0; snk_idle_pct = 0;

        wait (op_queue.size() == 0 && !s_tvalid && tes_expected.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0 && tes_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
